// ===== rtl/sfd_pkg.sv =====
// widths, sideband type and division step for the spring force pipeline
package sfd_pkg;

   localparam int POS_W   = 32;
   localparam int DIFF_W  = 33;
   localparam int PARM_W  = 31;
   localparam int SQ_W    = 66;
   localparam int ROOT_W  = 33;
   localparam int REM_W   = 36;

   // per item sideband that rides alongside the square root
   typedef struct packed {
      logic [DIFF_W-1:0] ax;
      logic [DIFF_W-1:0] ay;
      logic [PARM_W-1:0] rest;
      logic [PARM_W-1:0] stiff;
      logic              coincident;
      logic              dx_neg;
      logic              dy_neg;
   } sfd_side_type;

   // one restoring division step: {quotient bit, new remainder}
   function automatic logic [DIFF_W:0] div_step(input logic [DIFF_W:0]   part,
                                                input logic [DIFF_W-1:0] den);
      logic              ge;
      logic [DIFF_W:0]   diff;
      ge   = (part >= {1'b0, den});
      diff = part - {1'b0, den};
      div_step = ge ? {1'b1, diff[DIFF_W-1:0]} : {1'b0, part[DIFF_W-1:0]};
   endfunction

endpackage

// ===== rtl/sfd_sqrt.sv =====
// pipelined integer square root, one root bit per stage
module sfd_sqrt #(
   parameter int SIDE_W = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  logic                      in_valid,
   input  logic [sfd_pkg::SQ_W-1:0]  in_radicand,
   input  logic [SIDE_W-1:0]         in_side,
   output logic                      out_valid,
   output logic [sfd_pkg::ROOT_W-1:0] out_root,
   output logic [SIDE_W-1:0]         out_side
);
   import sfd_pkg::*;

   logic              valid_ff [ROOT_W];
   logic [REM_W-1:0]  rem_ff   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   logic [SQ_W-1:0]   rad_ff   [ROOT_W];
   logic [SIDE_W-1:0] side_ff  [ROOT_W];

   for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      logic              valid_prev;
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [SQ_W-1:0]   rad_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [REM_W-1:0]  shifted;
      logic [REM_W-1:0]  trial;
      logic              ge;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;
      logic [SQ_W-1:0]   rad_in;

      if (i == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign rad_prev   = in_radicand;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[i-1];
         assign rem_prev   = rem_ff[i-1];
         assign root_prev  = root_ff[i-1];
         assign rad_prev   = rad_ff[i-1];
         assign side_prev  = side_ff[i-1];
      end

      always_comb begin
         shifted = {rem_prev[REM_W-3:0], rad_prev[SQ_W-1 -: 2]};
         trial   = {{(REM_W-ROOT_W-2){1'b0}}, root_prev, 2'b01};
         ge      = (shifted >= trial);
         rem_in  = ge ? (shifted - trial) : shifted;
         root_in = {root_prev[ROOT_W-2:0], ge};
         rad_in  = {rad_prev[SQ_W-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (enable) begin
            valid_ff[i] <= valid_prev;
         end
         if (enable) begin
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            rad_ff[i]  <= rad_in;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

// ===== rtl/sfd_div.sv =====
// pipelined restoring divider for both unit vector components
module sfd_div #(
   parameter int FRAC_BITS = 16,
   parameter int SIDE_W    = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic                        in_valid,
   input  logic [sfd_pkg::DIFF_W-1:0]  in_num_x,
   input  logic [sfd_pkg::DIFF_W-1:0]  in_num_y,
   input  logic [sfd_pkg::DIFF_W-1:0]  in_den,
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_valid,
   output logic [FRAC_BITS:0]          out_quo_x,
   output logic [FRAC_BITS:0]          out_quo_y,
   output logic [SIDE_W-1:0]           out_side
);
   import sfd_pkg::*;

   localparam int STEPS = FRAC_BITS + 1;

   logic              valid_ff [STEPS];
   logic [DIFF_W-1:0] rx_ff    [STEPS];
   logic [DIFF_W-1:0] ry_ff    [STEPS];
   logic [DIFF_W-1:0] den_ff   [STEPS];
   logic [FRAC_BITS:0] qx_ff   [STEPS];
   logic [FRAC_BITS:0] qy_ff   [STEPS];
   logic [SIDE_W-1:0] side_ff  [STEPS];

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      logic               valid_prev;
      logic [DIFF_W:0]    part_x;
      logic [DIFF_W:0]    part_y;
      logic [DIFF_W-1:0]  den_prev;
      logic [FRAC_BITS:0] qx_prev;
      logic [FRAC_BITS:0] qy_prev;
      logic [SIDE_W-1:0]  side_prev;
      logic [DIFF_W:0]    res_x;
      logic [DIFF_W:0]    res_y;

      // first step takes the numerator as is: its quotient bit has weight one
      if (j == 0) begin : g_first
         assign valid_prev = in_valid;
         assign part_x     = {1'b0, in_num_x};
         assign part_y     = {1'b0, in_num_y};
         assign den_prev   = in_den;
         assign qx_prev    = '0;
         assign qy_prev    = '0;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[j-1];
         assign part_x     = {rx_ff[j-1], 1'b0};
         assign part_y     = {ry_ff[j-1], 1'b0};
         assign den_prev   = den_ff[j-1];
         assign qx_prev    = qx_ff[j-1];
         assign qy_prev    = qy_ff[j-1];
         assign side_prev  = side_ff[j-1];
      end

      assign res_x = div_step(part_x, den_prev);
      assign res_y = div_step(part_y, den_prev);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (enable) begin
            valid_ff[j] <= valid_prev;
         end
         if (enable) begin
            rx_ff[j]   <= res_x[DIFF_W-1:0];
            ry_ff[j]   <= res_y[DIFF_W-1:0];
            den_ff[j]  <= den_prev;
            qx_ff[j]   <= {qx_prev[FRAC_BITS-1:0], res_x[DIFF_W]};
            qy_ff[j]   <= {qy_prev[FRAC_BITS-1:0], res_y[DIFF_W]};
            side_ff[j] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_quo_x = qx_ff[STEPS-1];
   assign out_quo_y = qy_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

// ===== rtl/spring_force_2d_core.sv =====
// top level: hooke spring force between two bodies, fixed point pipeline
// throughput: one spring per cycle while rsp is not stalled, set by the fully pipelined root and divider stages
// a stalled rsp freezes the whole pipeline; req_stall follows it in the same cycle
// reset is synchronous: clears every stage valid bit, payload registers are left as they are
module spring_force_2d_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [31:0] req_end_a_x,
   input  logic signed [31:0] req_end_a_y,
   input  logic signed [31:0] req_end_b_x,
   input  logic signed [31:0] req_end_b_y,
   input  logic [30:0] req_rest_length,
   input  logic [30:0] req_stiffness,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_force_x,
   output logic signed [31:0] rsp_force_y,
   output logic        rsp_coincident,
   output logic        rsp_clipped
);
   import sfd_pkg::*;

   localparam int SIDE_W = $bits(sfd_side_type);
   localparam int M_W    = 64 - FRAC_BITS;        // force magnitude width
   localparam int DSIDE_W = M_W + 3;              // magnitude, two signs, coincident
   localparam int FP_W   = M_W + FRAC_BITS + 1;   // magnitude times unit component
   localparam int Q_W    = FP_W - FRAC_BITS;

   // one global advance: the pipeline moves unless a finished result is held
   logic adv;
   logic rsp_valid_ff;
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // stage 0: differences
   logic                     v0_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff;
   logic [PARM_W-1:0]        rest0_ff, stiff0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
      end
      if (adv) begin
         dx_ff     <= {req_end_a_x[31], req_end_a_x} - {req_end_b_x[31], req_end_b_x};
         dy_ff     <= {req_end_a_y[31], req_end_a_y} - {req_end_b_y[31], req_end_b_y};
         rest0_ff  <= req_rest_length;
         stiff0_ff <= req_stiffness;
      end
   end

   // stage 1: magnitudes and signs
   logic         v1_ff;
   sfd_side_type s1_ff, s1_in;

   always_comb begin
      s1_in.ax         = dx_ff[DIFF_W-1] ? DIFF_W'(-dx_ff) : DIFF_W'(dx_ff);
      s1_in.ay         = dy_ff[DIFF_W-1] ? DIFF_W'(-dy_ff) : DIFF_W'(dy_ff);
      s1_in.rest       = rest0_ff;
      s1_in.stiff      = stiff0_ff;
      s1_in.coincident = (dx_ff == '0) && (dy_ff == '0);
      s1_in.dx_neg     = dx_ff[DIFF_W-1];
      s1_in.dy_neg     = dy_ff[DIFF_W-1];
   end

   // stage 2: squares, stage 3: sum of squares
   logic            v2_ff, v3_ff;
   sfd_side_type    s2_ff, s3_ff;
   logic [SQ_W-1:0] sqx_ff, sqy_ff, sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (adv) begin
         s1_ff  <= s1_in;
         s2_ff  <= s1_ff;
         sqx_ff <= {{(SQ_W-DIFF_W){1'b0}}, s1_ff.ax} * {{(SQ_W-DIFF_W){1'b0}}, s1_ff.ax};
         sqy_ff <= {{(SQ_W-DIFF_W){1'b0}}, s1_ff.ay} * {{(SQ_W-DIFF_W){1'b0}}, s1_ff.ay};
         s3_ff  <= s2_ff;
         sum_ff <= sqx_ff + sqy_ff;
      end
   end

   // length by square root
   logic              vq_w;
   logic [ROOT_W-1:0] len_w;
   logic [SIDE_W-1:0] sq_side_w;
   sfd_side_type      sq_side;

   sfd_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .enable      (adv),
      .in_valid    (v3_ff),
      .in_radicand (sum_ff),
      .in_side     (SIDE_W'(s3_ff)),
      .out_valid   (vq_w),
      .out_root    (len_w),
      .out_side    (sq_side_w)
   );

   assign sq_side = sfd_side_type'(sq_side_w);

   // stage 4: extension from rest, force signs per component
   logic              v4_ff;
   sfd_side_type      s4_ff;
   logic [ROOT_W-1:0] len4_ff, xmag_ff;
   logic              negx4_ff, negy4_ff;

   // stage 5: k times extension
   logic              v5_ff;
   sfd_side_type      s5_ff;
   logic [ROOT_W-1:0] len5_ff;
   logic              negx5_ff, negy5_ff;
   logic [63:0]       mprod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= vq_w;
         v5_ff <= v4_ff;
      end
      if (adv) begin
         s4_ff   <= sq_side;
         len4_ff <= len_w;
         // stretched pulls toward the other end, compressed pushes away
         if (len_w >= ROOT_W'(sq_side.rest)) begin
            xmag_ff  <= len_w - ROOT_W'(sq_side.rest);
            negx4_ff <= !sq_side.dx_neg;
            negy4_ff <= !sq_side.dy_neg;
         end else begin
            xmag_ff  <= ROOT_W'(sq_side.rest) - len_w;
            negx4_ff <= sq_side.dx_neg;
            negy4_ff <= sq_side.dy_neg;
         end
         s5_ff    <= s4_ff;
         len5_ff  <= len4_ff;
         negx5_ff <= negx4_ff;
         negy5_ff <= negy4_ff;
         mprod_ff <= {{(64-PARM_W){1'b0}}, s4_ff.stiff} * {{(64-ROOT_W){1'b0}}, xmag_ff};
      end
   end

   // unit vector components by division, magnitude rides along
   logic               vd_w;
   logic [FRAC_BITS:0] ux_w, uy_w;
   logic [DSIDE_W-1:0] dside_w;
   logic [M_W-1:0]     mag_w;
   logic               negx_w, negy_w, coin_w;

   sfd_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(DSIDE_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (v5_ff),
      .in_num_x  (s5_ff.ax),
      .in_num_y  (s5_ff.ay),
      .in_den    (len5_ff),
      .in_side   ({mprod_ff[63:FRAC_BITS], negx5_ff, negy5_ff, s5_ff.coincident}),
      .out_valid (vd_w),
      .out_quo_x (ux_w),
      .out_quo_y (uy_w),
      .out_side  (dside_w)
   );

   assign {mag_w, negx_w, negy_w, coin_w} = dside_w;

   // stage 6: magnitude times unit component
   logic            v6_ff;
   logic [FP_W-1:0] fpx_ff, fpy_ff;
   logic            negx6_ff, negy6_ff, coin6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= vd_w;
      end
      if (adv) begin
         fpx_ff   <= {{(FP_W-M_W){1'b0}}, mag_w} * {{(FP_W-FRAC_BITS-1){1'b0}}, ux_w};
         fpy_ff   <= {{(FP_W-M_W){1'b0}}, mag_w} * {{(FP_W-FRAC_BITS-1){1'b0}}, uy_w};
         negx6_ff <= negx_w;
         negy6_ff <= negy_w;
         coin6_ff <= coin_w;
      end
   end

   // output stage: truncate, saturate, apply sign
   logic [Q_W-1:0] qx, qy, limx, limy;
   logic           clipx, clipy;
   logic [31:0]    fx_in, fy_in, magx, magy;

   always_comb begin
      qx    = fpx_ff[FP_W-1:FRAC_BITS];
      qy    = fpy_ff[FP_W-1:FRAC_BITS];
      limx  = negx6_ff ? Q_W'(33'h080000000) : Q_W'(33'h07fffffff);
      limy  = negy6_ff ? Q_W'(33'h080000000) : Q_W'(33'h07fffffff);
      clipx = (qx > limx);
      clipy = (qy > limy);
      magx  = clipx ? limx[31:0] : qx[31:0];
      magy  = clipy ? limy[31:0] : qy[31:0];
      fx_in = negx6_ff ? (32'd0 - magx) : magx;
      fy_in = negy6_ff ? (32'd0 - magy) : magy;
   end

   logic [31:0] rsp_fx_ff, rsp_fy_ff;
   logic        rsp_coin_ff, rsp_clip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v6_ff;
      end
      if (adv) begin
         // coincident ends: zero force, no saturation reported
         rsp_fx_ff   <= coin6_ff ? 32'd0 : fx_in;
         rsp_fy_ff   <= coin6_ff ? 32'd0 : fy_in;
         rsp_coin_ff <= coin6_ff;
         rsp_clip_ff <= !coin6_ff && (clipx || clipy);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_force_x    = rsp_fx_ff;
   assign rsp_force_y    = rsp_fy_ff;
   assign rsp_coincident = rsp_coin_ff;
   assign rsp_clipped    = rsp_clip_ff;

   // coincident ends never carry force or a saturation flag
   a_coincident_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_coincident |->
         rsp_force_x == 32'sd0 && rsp_force_y == 32'sd0 && !rsp_clipped)
      else $error("coincident result with nonzero force");

   // a saturated result has a component at a limit
   a_clip_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |->
         rsp_force_x == 32'sh7fffffff || rsp_force_x == 32'sh80000000 ||
         rsp_force_y == 32'sh7fffffff || rsp_force_y == 32'sh80000000)
      else $error("clipped flag without a saturated component");

   // the pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff && !v0_ff && !v6_ff)
      else $error("valid bit survived reset");

   // a held result stays valid and freezes the stage feeding it
   a_hold_freezes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(v6_ff) && rsp_valid_ff)
      else $error("pipeline moved while result held");

endmodule

// ===== dv/spring_force_checker.sv =====
`timescale 1ns / 100ps
// transfer monitor, force predictor and result comparison for spring_force_2d_core
module spring_force_checker #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_end_a_x,
   input  logic signed [31:0] req_end_a_y,
   input  logic signed [31:0] req_end_b_x,
   input  logic signed [31:0] req_end_b_y,
   input  logic [30:0]        req_rest_length,
   input  logic [30:0]        req_stiffness,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_force_x,
   input  logic signed [31:0] rsp_force_y,
   input  logic               rsp_coincident,
   input  logic               rsp_clipped,
   output int                 fail_count,
   output int                 pending,
   output int                 coincident_seen,
   output int                 clipped_seen
);

   typedef struct {
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic               coincident;
      logic               clipped;
   } spring_force_type;

   spring_force_type force_q[$];

   initial begin
      fail_count      = 0;
      pending         = 0;
      coincident_seen = 0;
      clipped_seen    = 0;
   end

   // floor square root of the squared length
   function automatic logic [33:0] length_root(input logic [65:0] sq);
      logic [33:0] root;
      logic [33:0] trial;
      root = '0;
      for (int b = 32; b >= 0; b--) begin
         trial = root | (34'd1 << b);
         if (68'(trial) * 68'(trial) <= 68'(sq)) root = trial;
      end
      return root;
   endfunction

   // one force component with saturation, magnitudes truncated toward zero
   function automatic logic [31:0] force_part(input logic [127:0] mag, input logic [32:0] dmag,
                                              input logic [33:0] len, input logic neg,
                                              inout logic clip);
      logic [127:0] unit;
      logic [127:0] q;
      logic [127:0] lim;
      unit = (128'(dmag) << FRAC_BITS) / 128'(len);
      q    = (mag * unit) >> FRAC_BITS;
      lim  = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      if (q > lim) begin
         q    = lim;
         clip = 1'b1;
      end
      return neg ? 32'(-q[31:0]) : q[31:0];
   endfunction

   function automatic spring_force_type predict_force(
         input logic signed [31:0] a_x, input logic signed [31:0] a_y,
         input logic signed [31:0] b_x, input logic signed [31:0] b_y,
         input logic [30:0] rest, input logic [30:0] stiff);
      spring_force_type r;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic [32:0]    adx;
      logic [32:0]    ady;
      logic [65:0]    sq;
      logic [33:0]    len;
      logic [33:0]    stretch;
      logic           squeezed;
      logic [127:0]   mag;
      logic           clip;
      dx = {a_x[31], a_x} - {b_x[31], b_x};
      dy = {a_y[31], a_y} - {b_y[31], b_y};
      r.force_x    = '0;
      r.force_y    = '0;
      r.coincident = 1'b0;
      r.clipped    = 1'b0;
      if (dx == 0 && dy == 0) begin
         r.coincident = 1'b1;
         return r;
      end
      adx = dx[32] ? 33'(-dx) : 33'(dx);
      ady = dy[32] ? 33'(-dy) : 33'(dy);
      sq  = 66'(adx) * 66'(adx) + 66'(ady) * 66'(ady);
      len = length_root(sq);
      squeezed = len < 34'(rest);
      stretch  = squeezed ? 34'(rest) - len : len - 34'(rest);
      mag  = (128'(stiff) * 128'(stretch)) >> FRAC_BITS;
      clip = 1'b0;
      // force pulls back against the stretch
      r.force_x = force_part(mag, adx, len, (!squeezed) != dx[32], clip);
      r.force_y = force_part(mag, ady, len, (!squeezed) != dy[32], clip);
      r.clipped = clip;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch on %s: got %h, wanted %h", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      spring_force_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            force_q.push_back(predict_force(req_end_a_x, req_end_a_y, req_end_b_x,
                                            req_end_b_y, req_rest_length, req_stiffness));
         end
         if (rsp_valid && !rsp_stall) begin
            if (force_q.size() == 0) begin
               report_mismatch("unexpected result", rsp_force_x, 32'd0);
            end else begin
               want = force_q.pop_front();
               if (rsp_force_x !== want.force_x)
                  report_mismatch("force_x", rsp_force_x, want.force_x);
               if (rsp_force_y !== want.force_y)
                  report_mismatch("force_y", rsp_force_y, want.force_y);
               if (rsp_coincident !== want.coincident)
                  report_mismatch("coincident", 32'(rsp_coincident), 32'(want.coincident));
               if (rsp_clipped !== want.clipped)
                  report_mismatch("clipped", 32'(rsp_clipped), 32'(want.clipped));
               if (want.coincident) coincident_seen <= coincident_seen + 1;
               if (want.clipped) clipped_seen <= clipped_seen + 1;
            end
         end
      end
      pending <= force_q.size();
   end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// stimulus, flow control and verdict for the spring force pipeline
module tb;

   localparam int FRAC_BITS  = 16;
   localparam int RAND_ITEMS = 1240;
   localparam int IDLE_LIMIT = 6000;   // cycles with no transfer on either side
   localparam int LONG_HOLD  = 400;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_end_a_x = '0;
   logic signed [31:0] req_end_a_y = '0;
   logic signed [31:0] req_end_b_x = '0;
   logic signed [31:0] req_end_b_y = '0;
   logic [30:0]        req_rest_length = '0;
   logic [30:0]        req_stiffness = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_force_x;
   logic signed [31:0] rsp_force_y;
   logic               rsp_coincident;
   logic               rsp_clipped;

   int fail_count;
   int pending;
   int coincident_seen;
   int clipped_seen;
   int springs_sent = 0;
   int idle_cycles  = 0;
   int stall_mode   = 0;
   int hold_left    = 0;
   logic hold_req   = 1'b0;
   logic hold_seen  = 1'b0;
   int cycle_no     = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   spring_force_2d_core #(.FRAC_BITS(FRAC_BITS)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_end_a_x(req_end_a_x), .req_end_a_y(req_end_a_y),
      .req_end_b_x(req_end_b_x), .req_end_b_y(req_end_b_y),
      .req_rest_length(req_rest_length), .req_stiffness(req_stiffness),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_force_x(rsp_force_x), .rsp_force_y(rsp_force_y),
      .rsp_coincident(rsp_coincident), .rsp_clipped(rsp_clipped)
   );

   spring_force_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_end_a_x(req_end_a_x), .req_end_a_y(req_end_a_y),
      .req_end_b_x(req_end_b_x), .req_end_b_y(req_end_b_y),
      .req_rest_length(req_rest_length), .req_stiffness(req_stiffness),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_force_x(rsp_force_x), .rsp_force_y(rsp_force_y),
      .rsp_coincident(rsp_coincident), .rsp_clipped(rsp_clipped),
      .fail_count(fail_count), .pending(pending),
      .coincident_seen(coincident_seen), .clipped_seen(clipped_seen)
   );

   // receiver: a long hold-off on request, otherwise a stall pattern per phase
   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
               // stall in periodic runs, drifting against the sender bursts
               rsp_stall <= (cycle_no % 13) < 5;
            end
            default: begin
               rsp_stall <= ($urandom_range(0, 1) == 1);
            end
         endcase
      end
   end

   // watchdog: a stretch past IDLE_LIMIT without a transfer on either side is a hang
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // offer one spring and hold it until the transfer happens
   task automatic send_spring(input logic signed [31:0] a_x, input logic signed [31:0] a_y,
                              input logic signed [31:0] b_x, input logic signed [31:0] b_y,
                              input logic [30:0] rest, input logic [30:0] stiff);
      req_valid       <= 1'b1;
      req_end_a_x     <= a_x;
      req_end_a_y     <= a_y;
      req_end_b_x     <= b_x;
      req_end_b_y     <= b_y;
      req_rest_length <= rest;
      req_stiffness   <= stiff;
      do @(posedge clock); while (req_stall);
      springs_sent++;
   endtask

   // drop valid for a random gap, only between bursts
   task automatic sender_gap(input int max_gap);
      int gap;
      gap = $urandom_range(1, max_gap);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // one random spring: mostly realistic scenes, some wide noise and corner shapes
   task automatic random_spring();
      logic signed [31:0] a_x, a_y, b_x, b_y;
      logic [30:0]        rest, stiff;
      int                 shape;
      shape = $urandom_range(0, 9);
      a_x   = $urandom;
      a_y   = $urandom;
      rest  = 31'($urandom);
      stiff = 31'($urandom);
      case (shape)
         0, 1: begin
            // full width noise
            b_x = $urandom;
            b_y = $urandom;
         end
         2: begin
            // ends on top of each other
            b_x = a_x;
            b_y = a_y;
         end
         3: begin
            // axis aligned, at rest length unless b_x wraps: zero force
            b_x  = a_x - 32'($urandom_range(1, 32'h7fff_ffff));
            b_y  = a_y;
            rest = 31'((a_x - b_x));
         end
         default: begin
            // nearby bodies with moderate springs
            b_x   = a_x + $signed(32'($urandom_range(0, 32'h0100_0000))) - 32'h0080_0000;
            b_y   = a_y + $signed(32'($urandom_range(0, 32'h0100_0000))) - 32'h0080_0000;
            rest  = 31'($urandom_range(0, 32'h0080_0000));
            stiff = 31'($urandom_range(0, 32'h0040_0000));
         end
      endcase
      send_spring(a_x, a_y, b_x, b_y, rest, stiff);
   endtask

   localparam logic signed [31:0] POS_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
   localparam logic [30:0]        PAR_MAX = 31'h7fff_ffff;
   localparam logic [30:0]        ONE     = 31'h0001_0000;

   initial begin
      int burst;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners with a free-running receiver
      stall_mode = 0;
      send_spring(0, 0, 0, 0, ONE, ONE);                          // coincident ends
      send_spring(POS_MIN, POS_MAX, POS_MIN, POS_MAX, PAR_MAX, PAR_MAX);
      send_spring(32'sh0003_0000, 0, 0, 0, 31'h0003_0000, PAR_MAX); // exactly at rest
      send_spring(0, 32'sh0004_0000, 0, 0, 31'h0004_0000, ONE);
      send_spring(POS_MAX, POS_MAX, POS_MIN, POS_MIN, 0, PAR_MAX);  // longest, clips
      send_spring(POS_MIN, POS_MIN, POS_MAX, POS_MAX, 0, PAR_MAX);
      send_spring(POS_MAX, POS_MIN, POS_MIN, POS_MAX, PAR_MAX, PAR_MAX);
      send_spring(POS_MAX, POS_MIN, POS_MIN, POS_MAX, 0, 0);        // no stiffness
      send_spring(1, 0, 0, 0, 0, ONE);                              // shortest lengths
      send_spring(0, -1, 0, 0, PAR_MAX, PAR_MAX);                   // compressed hard
      send_spring(0, 0, 1, 1, PAR_MAX, ONE);
      send_spring(32'sh0001_0000, 32'sh0001_0000, 0, 0, ONE, ONE);  // each sign quadrant
      send_spring(-32'sh0001_0000, 32'sh0001_0000, 0, 0, ONE, ONE);
      send_spring(32'sh0001_0000, -32'sh0001_0000, 0, 0, ONE, ONE);
      send_spring(-32'sh0001_0000, -32'sh0001_0000, 0, 0, 31'h0010_0000, ONE);
      send_spring(32'sh0030_0000, 32'sh0040_0000, 0, 0, 31'h0001_0000, 31'h0002_8000);
      send_spring(32'sh0030_0000, 32'sh0040_0000, 0, 0, 31'h0100_0000, 31'h0002_8000);
      send_spring(0, 0, 32'sh0000_0001, 32'sh7fff_ffff, 31'h5555_5555, 31'h2aaa_aaaa);
      send_spring(0, 0, POS_MIN, 0, PAR_MAX, 31'h0000_0001);
      send_spring(POS_MAX, 0, POS_MIN, 0, PAR_MAX, PAR_MAX);
      wait_drained();

      // back pressure: receiver holds off while the sender keeps offering
      stall_mode = 0;
      hold_req  <= ~hold_req;
      repeat (150) random_spring();
      wait_drained();

      // random phases, each under a different stall pattern
      for (int phase = 0; phase < 4; phase++) begin
         stall_mode = phase;
         for (int n = 0; n < RAND_ITEMS / 4; n += burst) begin
            burst = $urandom_range(1, 24);
            repeat (burst) random_spring();
            if ($urandom_range(0, 3) != 0) sender_gap(phase == 0 ? 3 : 12);
         end
         // sender pause until the pipeline has emptied
         wait_drained();
      end

      stall_mode = 1;
      wait_drained();
      repeat (80) @(posedge clock);

      $display("covered %0d springs: corners, back pressure hold-off, four stall patterns",
               springs_sent);
      $display("coincident results %0d, saturated results %0d, still queued %0d",
               coincident_seen, clipped_seen, pending);
      if (fail_count == 0 && pending == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/sfd_pkg.sv
rtl/sfd_sqrt.sv
rtl/sfd_div.sv
rtl/spring_force_2d_core.sv
dv/spring_force_checker.sv
dv/tb.sv
